### hdl/msxu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msxu_pkg
// Shared types, operation codes and sizes for the integer execute unit.
// ----------------------------------------------------------------------------
package msxu_pkg;

   // data memory size in words; must be a power of two
   localparam int MEM_WORDS = 1024;
   localparam int MEM_IDX_W = $clog2(MEM_WORDS);

   // operation codes
   localparam logic [4:0] OP_MFLO = 5'd0;
   localparam logic [4:0] OP_MFHI = 5'd1;
   localparam logic [4:0] OP_JR   = 5'd2;
   localparam logic [4:0] OP_MULT = 5'd3;
   localparam logic [4:0] OP_DIV  = 5'd4;
   localparam logic [4:0] OP_ADD  = 5'd5;
   localparam logic [4:0] OP_SUB  = 5'd6;
   localparam logic [4:0] OP_AND  = 5'd7;
   localparam logic [4:0] OP_OR   = 5'd8;
   localparam logic [4:0] OP_XOR  = 5'd9;
   localparam logic [4:0] OP_SLT  = 5'd10;
   localparam logic [4:0] OP_ROTR = 5'd11;
   localparam logic [4:0] OP_SLL  = 5'd12;
   localparam logic [4:0] OP_SRL  = 5'd13;
   localparam logic [4:0] OP_ADDI = 5'd14;
   localparam logic [4:0] OP_LW   = 5'd15;
   localparam logic [4:0] OP_SW   = 5'd16;
   localparam logic [4:0] OP_LUI  = 5'd17;
   localparam logic [4:0] OP_BEQ  = 5'd18;
   localparam logic [4:0] OP_BNE  = 5'd19;
   localparam logic [4:0] OP_BGTZ = 5'd20;
   localparam logic [4:0] OP_BLEZ = 5'd21;
   localparam logic [4:0] OP_J    = 5'd22;
   localparam logic [4:0] OP_JAL  = 5'd23;

   localparam logic [4:0] LINK_REG = 5'd31;

   typedef struct packed {
      logic [4:0]         action;
      logic [4:0]         dest_reg;
      logic [4:0]         src_reg_a;
      logic [4:0]         src_reg_b;
      logic [4:0]         shift_amount;
      logic signed [15:0] immediate;
      logic [31:0]        jump_target;
   } req_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        reg_write;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        hilo_write;
      logic [31:0] hi_value;
      logic [31:0] lo_value;
      logic        mem_write;
      logic [31:0] mem_address;
      logic [31:0] mem_value;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_DIVW,
      ST_EXEC
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear;      // zero one data memory word
      logic accept;     // latch request, read register file
      logic prep;       // operands valid: multiply, memory read
      logic div_start;  // load the divider
      logic commit;     // update state, register response
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic op_div;
      logic div_done;
   } sts_type;

endpackage

### hdl/mips_subset_execute_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_subset_execute_unit_core
// Executes one decoded integer instruction per request.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_item) is taken at a clock edge with start high and busy
//   low. Exactly one response follows on rsp_item, marked by rsp_strobe for
//   one cycle; the receiver cannot stall, so it must take it then.
// Sequence:
//   Most instructions: accept, operand read, execute; the response is
//   registered when the execute state ends and is taken at the edge that
//   ends rsp_strobe, where a new request can already be taken.
//   DIV inserts a divide wait state after the operand read, which loads
//   the iterative divider; it is left once all quotient bits are done.
//   The register file read port and the registered data memory read set
//   the operand and load stages.
// Reset:
//   Synchronous, active high. Registers, HI, LO and PC read zero at once;
//   the data memory is zeroed by a clearing pass over all MEM_WORDS
//   (1024) words, during which busy stays high.
// ----------------------------------------------------------------------------
module mips_subset_execute_unit_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  msxu_pkg::req_type req_item,
   output logic              rsp_strobe,
   output msxu_pkg::rsp_type rsp_item
);
   import msxu_pkg::*;

   cmd_type cmd;
   sts_type sts;

   msxu_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   msxu_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

### hdl/msxu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msxu_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msxu_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);

   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [32:0] shifted;
   logic [32:0] diff;

   // one restoring step
   always_comb begin
      shifted = {rem_ff[31:0], quo_ff[31]};
      diff    = shifted - {1'b0, dvs_ff};
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         cnt_in = 6'd32;
         rem_in = 33'd0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (cnt_ff != 6'd0) begin
         cnt_in = cnt_ff - 6'd1;
         if (!diff[32]) begin
            rem_in = diff;
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 6'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done      = (cnt_ff == 6'd0);
   assign quotient  = quo_ff;
   assign remainder = rem_ff[31:0];

endmodule

### hdl/msxu_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msxu_dpath
// Register file, HI/LO, PC, data memory, multiplier, divider and result logic.
// ----------------------------------------------------------------------------
module msxu_dpath (
   input  logic             clock,
   input  logic             reset,
   input  msxu_pkg::cmd_type cmd,
   output msxu_pkg::sts_type sts,
   input  msxu_pkg::req_type req_item,
   output logic             rsp_strobe,
   output msxu_pkg::rsp_type rsp_item
);
   import msxu_pkg::*;

   req_type               req_ff;
   logic [31:0]           rf_mem [32];
   logic [31:0]           rf_valid_ff;
   logic [31:0]           rf_a_ff, rf_b_ff;
   logic [31:0]           dm_mem [MEM_WORDS];
   logic [31:0]           dm_rdata_ff;
   logic [MEM_IDX_W-1:0]  clr_cnt_ff;
   logic [31:0]           pc_ff, hi_ff, lo_ff;
   logic signed [63:0]    prod_ff, prod_in;
   logic                  strobe_ff;
   rsp_type               rsp_ff, rsp_in;
   logic [31:0]           imm32, addr;
   logic [MEM_IDX_W-1:0]  widx_mem;
   logic [31:0]           ua, ub, quo, rem;
   logic                  div_done;
   logic                  na, nb, taken, wr;
   logic [4:0]            widx;
   logic [31:0]           wval, npc, hi_n, lo_n;

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_item;
      end
   end

   // register file with valid bits, registered reads
   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff <= '0;
      end else if (cmd.commit && wr) begin
         rf_valid_ff[widx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && wr) begin
         rf_mem[widx] <= wval;
      end
      if (cmd.accept) begin
         rf_a_ff <= rf_valid_ff[req_item.src_reg_a] ? rf_mem[req_item.src_reg_a] : 32'd0;
         rf_b_ff <= rf_valid_ff[req_item.src_reg_b] ? rf_mem[req_item.src_reg_b] : 32'd0;
      end
   end

   // address and operand helpers
   assign imm32    = {{16{req_ff.immediate[15]}}, req_ff.immediate};
   assign addr     = rf_a_ff + imm32;
   assign widx_mem = addr[2 +: MEM_IDX_W];
   assign na       = rf_a_ff[31];
   assign nb       = rf_b_ff[31];
   assign ua       = na ? (32'd0 - rf_a_ff) : rf_a_ff;
   assign ub       = nb ? (32'd0 - rf_b_ff) : rf_b_ff;
   assign prod_in  = $signed(rf_a_ff) * $signed(rf_b_ff);

   // clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // data memory
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         dm_mem[clr_cnt_ff] <= 32'd0;
      end else if (cmd.commit && req_ff.action == OP_SW) begin
         dm_mem[widx_mem] <= rf_b_ff;
      end
      if (cmd.prep) begin
         dm_rdata_ff <= dm_mem[widx_mem];
      end
   end

   // multiplier output register
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         prod_ff <= prod_in;
      end
   end

   msxu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (ua),
      .divisor   (ub),
      .done      (div_done),
      .quotient  (quo),
      .remainder (rem)
   );

   // result logic
   always_comb begin
      npc   = pc_ff + 32'd4;
      wr    = 1'b0;
      widx  = req_ff.dest_reg;
      wval  = 32'd0;
      hi_n  = hi_ff;
      lo_n  = lo_ff;
      taken = 1'b0;
      rsp_in = '0;
      case (req_ff.action)
         OP_MFLO: begin wr = 1'b1; wval = lo_ff; end
         OP_MFHI: begin wr = 1'b1; wval = hi_ff; end
         OP_JR:   npc = rf_a_ff;
         OP_MULT: begin
            rsp_in.hilo_write = 1'b1;
            hi_n = prod_ff[63:32];
            lo_n = prod_ff[31:0];
         end
         OP_DIV: begin
            if (rf_b_ff != 32'd0) begin
               rsp_in.hilo_write = 1'b1;
               lo_n = (na != nb) ? (32'd0 - quo) : quo;
               hi_n = na ? (32'd0 - rem) : rem;
            end
         end
         OP_ADD:  begin wr = 1'b1; wval = rf_a_ff + rf_b_ff; end
         OP_SUB:  begin wr = 1'b1; wval = rf_a_ff - rf_b_ff; end
         OP_AND:  begin wr = 1'b1; wval = rf_a_ff & rf_b_ff; end
         OP_OR:   begin wr = 1'b1; wval = rf_a_ff | rf_b_ff; end
         OP_XOR:  begin wr = 1'b1; wval = rf_a_ff ^ rf_b_ff; end
         OP_SLT: begin
            wr   = 1'b1;
            wval = {31'd0, $signed(rf_a_ff) < $signed(rf_b_ff)};
         end
         OP_ROTR: begin
            wr   = 1'b1;
            wval = 32'({rf_b_ff, rf_b_ff} >> req_ff.shift_amount);
         end
         OP_SLL:  begin wr = 1'b1; wval = rf_b_ff << req_ff.shift_amount; end
         OP_SRL:  begin wr = 1'b1; wval = rf_b_ff >> req_ff.shift_amount; end
         OP_ADDI: begin wr = 1'b1; wval = addr; end
         OP_LW: begin
            wr = 1'b1;
            wval = dm_rdata_ff;
            rsp_in.mem_address = addr;
            rsp_in.mem_value   = dm_rdata_ff;
         end
         OP_SW: begin
            rsp_in.mem_write   = 1'b1;
            rsp_in.mem_address = addr;
            rsp_in.mem_value   = rf_b_ff;
         end
         OP_LUI:  begin wr = 1'b1; wval = {req_ff.immediate, 16'd0}; end
         OP_BEQ:  taken = (rf_a_ff == rf_b_ff);
         OP_BNE:  taken = (rf_a_ff != rf_b_ff);
         OP_BGTZ: taken = ($signed(rf_a_ff) > 0);
         OP_BLEZ: taken = !($signed(rf_a_ff) > 0);
         OP_J:    npc = req_ff.jump_target;
         OP_JAL: begin
            wr   = 1'b1;
            widx = LINK_REG;
            wval = pc_ff + 32'd4;
            npc  = req_ff.jump_target;
         end
         default: ;
      endcase
      if (taken) begin
         npc = pc_ff + imm32;
      end
      // writes to r0 are dropped
      if (!(wr && widx != 5'd0)) begin
         wr   = 1'b0;
         widx = 5'd0;
         wval = 32'd0;
      end
      rsp_in.next_pc   = npc;
      rsp_in.reg_write = wr;
      rsp_in.reg_index = widx;
      rsp_in.reg_value = wval;
      rsp_in.hi_value  = hi_n;
      rsp_in.lo_value  = lo_n;
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= 32'd0;
         hi_ff <= 32'd0;
         lo_ff <= 32'd0;
      end else if (cmd.commit) begin
         pc_ff <= npc;
         hi_ff <= hi_n;
         lo_ff <= lo_n;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.commit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_item       = rsp_ff;
   assign sts.clear_last = (clr_cnt_ff == MEM_IDX_W'(MEM_WORDS - 1));
   assign sts.op_div     = (req_ff.action == OP_DIV);
   assign sts.div_done   = div_done;

`ifndef SYNTHESIS
   a_strobe_from_commit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(cmd.commit))
      else $error("response without commit");
   a_r0_never_written: assert property (@(posedge clock) disable iff (reset)
      !rf_valid_ff[0])
      else $error("register zero marked written");
   a_no_write_r0: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.reg_write |-> rsp_item.reg_index != 5'd0)
      else $error("write reported to register zero");
`endif

endmodule

### hdl/msxu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msxu_ctrl
// Sequencer: memory clearing, operand read, divide wait and commit.
// ----------------------------------------------------------------------------
module msxu_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  msxu_pkg::sts_type sts,
   output msxu_pkg::cmd_type cmd
);
   import msxu_pkg::*;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (sts.clear_last) state_in = ST_IDLE;
         ST_IDLE:  if (start) state_in = ST_READ;
         ST_READ:  state_in = sts.op_div ? ST_DIVW : ST_EXEC;
         ST_DIVW:  if (sts.div_done) state_in = ST_EXEC;
         ST_EXEC:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_CLEAR: cmd.clear = 1'b1;
         ST_IDLE: begin
            busy       = 1'b0;
            cmd.accept = start;
         end
         ST_READ: begin
            cmd.prep      = 1'b1;
            cmd.div_start = sts.op_div;
         end
         ST_DIVW: ;
         ST_EXEC: cmd.commit = 1'b1;
         default: ;
      endcase
   end

`ifndef SYNTHESIS
   a_accept_to_read: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == ST_READ)
      else $error("accept did not start a request");
   a_commit_single: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> !cmd.commit && !busy)
      else $error("commit not followed by idle");
   a_divw_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVW && !sts.div_done |=> state_ff == ST_DIVW)
      else $error("left divide wait early");
`endif

endmodule
